// ===== sv/fcht_pkg.sv =====
// Package: shared constants, types and controller states for the frequency count hash table.
`timescale 1ns / 1ps
package fcht_pkg;
  localparam int unsigned BUCKETS_DEF = 256;
  localparam int unsigned WAYS_DEF = 4;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CFG_BITS = 9;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned OCC_BITS = 16;
  localparam int unsigned SUM_BITS = 10;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_MOD,
    ST_PROBE,
    ST_WRITE,
    ST_DONE,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic digit;
    logic mod_step;
    logic probe_start;
    logic probe_step;
    logic commit;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic digits_done;
    logic mod_done;
    logic probe_done;
  } stat_t;
endpackage

// ===== sv/fcht_datapath.sv =====
// Datapath: digit sum, bucket modulo, way probe and table storage.
`timescale 1ns / 1ps
module fcht_datapath #(
  parameter int unsigned BUCKETS = fcht_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS = fcht_pkg::WAYS_DEF,
  parameter int unsigned COUNT_BITS = fcht_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fcht_pkg::cmd_t                  cmd_i,
  output fcht_pkg::stat_t                 stat_o,
  input  logic                            action_i,
  input  logic [fcht_pkg::KEY_BITS-1:0]   key_value_i,
  input  logic [fcht_pkg::CFG_BITS-1:0]   bucket_count_i,
  output logic                            found_o,
  output logic [fcht_pkg::OCC_BITS-1:0]   occurrences_o,
  output logic                            bucket_full_o
);
  localparam int unsigned SLOTS = BUCKETS * WAYS;
  localparam int unsigned SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned BB = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WCB = $clog2(WAYS + 1);
  localparam int unsigned BCB = $clog2(BUCKETS + 1);
  localparam int unsigned MB = (BCB > fcht_pkg::SUM_BITS) ? BCB : fcht_pkg::SUM_BITS;
  localparam int unsigned KB = fcht_pkg::KEY_BITS;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [KB-1:0] key_mem [SLOTS];
  logic [COUNT_BITS-1:0] cnt_mem [SLOTS];
  logic vld_mem [SLOTS];
  logic [SB-1:0] clr_q;

  logic act_q;
  logic [KB-1:0] key_q;
  logic [KB-1:0] mag_q, mag_d;
  logic [fcht_pkg::SUM_BITS-1:0] sum_q, sum_d;
  logic [MB-1:0] rem_q;
  logic [WCB-1:0] way_q;
  logic [SB-1:0] base_q, addr;
  logic hit_q, free_q;
  logic [SB-1:0] hit_slot_q, free_slot_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic [KB-1:0] rd_key_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  logic rd_vld_q, rd_live_q;
  logic [SB-1:0] rd_slot_q;
  logic [3:0] digit;
  logic [KB-1:0] quot;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [BCB-1:0] bc_use;
  logic [MB-1:0] bc_ext;

  always_comb begin
    if (bucket_count_i == '0) begin
      bc_use = BCB'(1);
    end else if (32'(bucket_count_i) > BUCKETS) begin
      bc_use = BCB'(BUCKETS);
    end else begin
      bc_use = BCB'(bucket_count_i);
    end
    bc_ext = MB'(bc_use);
  end

  assign quot = KB'((64'(mag_q) * 64'hCCCCCCCD) >> 35);
  assign digit = 4'(mag_q - KB'(quot * KB'(10)));
  assign mag_d = quot;
  assign sum_d = sum_q + fcht_pkg::SUM_BITS'(48) + fcht_pkg::SUM_BITS'(digit);
  assign stat_o.clear_done = (clr_q == SB'(SLOTS - 1));
  assign stat_o.digits_done = (mag_q < KB'(10));
  assign stat_o.mod_done = (rem_q < bc_ext);
  assign stat_o.probe_done = (way_q == WCB'(WAYS)) && !rd_live_q;
  assign addr = SB'(base_q + SB'(way_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + SB'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      vld_mem[clr_q] <= 1'b0;
    end else if (cmd_i.commit && !hit_q && act_q == fcht_pkg::ACT_INSERT && free_q) begin
      vld_mem[free_slot_q] <= 1'b1;
    end
    rd_vld_q <= vld_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (hit_q) begin
        cnt_mem[hit_slot_q] <= new_cnt;
      end else if (free_q) begin
        key_mem[free_slot_q] <= key_q;
        cnt_mem[free_slot_q] <= COUNT_BITS'(1);
      end
    end
    rd_key_q <= key_mem[addr];
    rd_cnt_q <= cnt_mem[addr];
  end

  assign new_cnt = (act_q == fcht_pkg::ACT_INSERT && hit_cnt_q != CMAX) ?
                   hit_cnt_q + COUNT_BITS'(1) : hit_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      key_q <= key_value_i;
      mag_q <= key_value_i[KB-1] ? (~key_value_i + KB'(1)) : key_value_i;
      sum_q <= key_value_i[KB-1] ? fcht_pkg::SUM_BITS'(45) : '0;
    end else if (cmd_i.digit) begin
      mag_q <= mag_d;
      sum_q <= sum_d;
      if (stat_o.digits_done) begin
        rem_q <= MB'(sum_d);
      end
    end else if (cmd_i.mod_step) begin
      if (!stat_o.mod_done) begin
        rem_q <= rem_q - bc_ext;
      end
    end
    if (cmd_i.probe_start) begin
      base_q <= SB'(BB'(rem_q) * WAYS);
      way_q <= '0;
      rd_live_q <= 1'b0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.probe_step) begin
      if (way_q != WCB'(WAYS)) begin
        way_q <= way_q + WCB'(1);
        rd_slot_q <= addr;
        rd_live_q <= 1'b1;
      end else begin
        rd_live_q <= 1'b0;
      end
      if (rd_live_q) begin
        if (rd_vld_q) begin
          if (!hit_q && rd_key_q == key_q) begin
            hit_q <= 1'b1;
            hit_slot_q <= rd_slot_q;
            hit_cnt_q <= rd_cnt_q;
          end
        end else if (!free_q) begin
          free_q <= 1'b1;
          free_slot_q <= rd_slot_q;
        end
      end
    end
    if (cmd_i.commit) begin
      found_o <= hit_q;
      bucket_full_o <= !hit_q && act_q == fcht_pkg::ACT_INSERT && !free_q;
      if (hit_q) begin
        occurrences_o <= (COUNT_BITS > fcht_pkg::OCC_BITS &&
                          (new_cnt >> fcht_pkg::OCC_BITS) != '0) ?
                         '1 : fcht_pkg::OCC_BITS'(new_cnt);
      end else begin
        occurrences_o <= (act_q == fcht_pkg::ACT_INSERT && free_q) ?
                         fcht_pkg::OCC_BITS'(1) : '0;
      end
    end
  end
endmodule

// ===== sv/fcht_ctrl.sv =====
// Controller: sequences digit sum, modulo, probe and write-back.
`timescale 1ns / 1ps
module fcht_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output logic            done_o,
  output fcht_pkg::cmd_t  cmd_o,
  input  fcht_pkg::stat_t stat_i
);
  fcht_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcht_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      fcht_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_done) begin
          state_d = fcht_pkg::ST_IDLE;
        end
      end
      fcht_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = fcht_pkg::ST_DIGIT;
        end
      end
      fcht_pkg::ST_DIGIT: begin
        cmd_o.digit = 1'b1;
        if (stat_i.digits_done) begin
          state_d = fcht_pkg::ST_MOD;
        end
      end
      fcht_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_done) begin
          cmd_o.probe_start = 1'b1;
          state_d = fcht_pkg::ST_PROBE;
        end
      end
      fcht_pkg::ST_PROBE: begin
        cmd_o.probe_step = 1'b1;
        if (stat_i.probe_done) begin
          state_d = fcht_pkg::ST_WRITE;
        end
      end
      fcht_pkg::ST_WRITE: begin
        cmd_o.commit = 1'b1;
        state_d = fcht_pkg::ST_DONE;
      end
      fcht_pkg::ST_DONE: begin
        done_o = 1'b1;
        cmd_o.done = 1'b1;
        state_d = fcht_pkg::ST_IDLE;
      end
      default: state_d = fcht_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== sv/frequency_count_hash_table_unit.sv =====
// Top level: frequency count hash table with controller and datapath.
// A word passes the digit loop, the repeated-subtract modulo and the single-port way probe,
// then write-back and done_o; the next start is not taken until the cycle after done_o.
// Reset sets bucket_count to 256 and clears the way valid bits one slot a cycle with busy high.
// The receiver cannot stall: done_o marks each result for one cycle.
`timescale 1ns / 1ps
module frequency_count_hash_table_unit #(
  parameter int unsigned BUCKETS = fcht_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS = fcht_pkg::WAYS_DEF,
  parameter int unsigned COUNT_BITS = fcht_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [fcht_pkg::KEY_BITS-1:0] key_value_i,
  input  logic                          cfg_we_i,
  input  logic [fcht_pkg::CFG_BITS-1:0] cfg_wdata_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [fcht_pkg::OCC_BITS-1:0] occurrences_o,
  output logic                          bucket_full_o
);
  fcht_pkg::cmd_t cmd;
  fcht_pkg::stat_t stat;
  logic [fcht_pkg::CFG_BITS-1:0] bucket_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= fcht_pkg::CFG_BITS'(256);
    end else if (cfg_we_i) begin
      bucket_count_q <= cfg_wdata_i;
    end
  end

  fcht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  fcht_datapath #(
    .BUCKETS    (BUCKETS),
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .action_i       (action_i),
    .key_value_i    (key_value_i),
    .bucket_count_i (bucket_count_q),
    .found_o        (found_o),
    .occurrences_o  (occurrences_o),
    .bucket_full_o  (bucket_full_o)
  );
endmodule

// ===== tb/sv/tb_frequency_count_hash_table_unit.sv =====
// Testbench: checks the frequency count hash table against its own model, word by word.
`timescale 1ns / 1ps
module tb_frequency_count_hash_table_unit;
  import fcht_pkg::*;

  localparam int unsigned SLOTS = BUCKETS_DEF * WAYS_DEF;
  localparam int unsigned CNT_MAX = (1 << COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic                found;
    logic [OCC_BITS-1:0] occ;
    logic                full;
  } tally_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                action_i = ACT_INSERT;
  logic [KEY_BITS-1:0] key_value_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata_i = '0;
  logic                done_o;
  logic                found_o;
  logic [OCC_BITS-1:0] occurrences_o;
  logic                bucket_full_o;

  logic [KEY_BITS-1:0] tbl_key [SLOTS];
  int unsigned         tbl_cnt [SLOTS];
  bit                  tbl_vld [SLOTS];
  logic [CFG_BITS-1:0] mod_reg;
  tally_t              tally_q [$];
  int unsigned         errors = 0;
  bit                  idle_en = 1'b1;
  logic [KEY_BITS-1:0] pool [64];

  frequency_count_hash_table_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .action_i(action_i), .key_value_i(key_value_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o), .found_o(found_o), .occurrences_o(occurrences_o),
    .bucket_full_o(bucket_full_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned digit_sum(logic [KEY_BITS-1:0] k);
    int unsigned s;
    longint unsigned mag;
    s = 0;
    if (k[KEY_BITS-1]) begin
      s = 45;
      mag = 64'd4294967296 - {32'd0, k};
    end else begin
      mag = {32'd0, k};
    end
    do begin
      s += 48 + int'(mag % 10);
      mag /= 10;
    end while (mag != 0);
    return s;
  endfunction

  function automatic tally_t count_key(logic act, logic [KEY_BITS-1:0] k);
    tally_t t;
    int unsigned nb, base;
    int hit, free_w;
    t = '0;
    hit = -1;
    free_w = -1;
    nb = (mod_reg == 0) ? 1 : (mod_reg > BUCKETS_DEF ? BUCKETS_DEF : mod_reg);
    base = (digit_sum(k) % nb) * WAYS_DEF;
    for (int w = 0; w < WAYS_DEF; w++) begin
      if (tbl_vld[base + w]) begin
        if (hit < 0 && tbl_key[base + w] == k) hit = base + w;
      end else if (free_w < 0) begin
        free_w = base + w;
      end
    end
    if (hit >= 0) begin
      t.found = 1'b1;
      if (act == ACT_INSERT && tbl_cnt[hit] < CNT_MAX) tbl_cnt[hit]++;
      t.occ = (tbl_cnt[hit] > 65535) ? 16'hFFFF : tbl_cnt[hit][15:0];
    end else if (act == ACT_INSERT) begin
      if (free_w >= 0) begin
        tbl_vld[free_w] = 1'b1;
        tbl_key[free_w] = k;
        tbl_cnt[free_w] = 1;
        t.occ = 1;
      end else begin
        t.full = 1'b1;
      end
    end
    return t;
  endfunction

  always @(posedge clk_i) begin
    tally_t exp_t;
    if (rst_ni && done_o) begin
      if (tally_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: found %0b occ %0d full %0b",
                                   found_o, occurrences_o, bucket_full_o);
      end else begin
        exp_t = tally_q.pop_front();
        if (found_o !== exp_t.found || occurrences_o !== exp_t.occ ||
            bucket_full_o !== exp_t.full) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp found %0b occ %0d full %0b, got %0b %0d %0b",
                     exp_t.found, exp_t.occ, exp_t.full,
                     found_o, occurrences_o, bucket_full_o);
        end
      end
    end
  end

  task automatic send_word(logic act, logic [KEY_BITS-1:0] k);
    start <= 1'b1;
    action_i <= act;
    key_value_i <= k;
    do @(posedge clk_i); while (busy);
    tally_q.push_back(count_key(act, k));
    if (idle_en && $urandom_range(99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    @(posedge clk_i);
    start <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_buckets(logic [CFG_BITS-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    mod_reg = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_word(ACT_LOOKUP, 32'h8000_0000);
    send_word(ACT_INSERT, 32'h8000_0000);
    send_word(ACT_INSERT, 32'h7FFF_FFFF);
    send_word(ACT_INSERT, 32'h7FFF_FFFF);
    send_word(ACT_LOOKUP, 32'h7FFF_FFFF);
    send_word(ACT_INSERT, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'h8000_0000);
    set_buckets(9'd1);
    for (int i = 0; i < 6; i++) send_word(ACT_INSERT, 32'd1000 + i);
    send_word(ACT_LOOKUP, 32'd1005);
    send_word(ACT_LOOKUP, 32'd1001);
    set_buckets(9'd0);
    send_word(ACT_INSERT, 32'd1001);
    send_word(ACT_INSERT, 32'd77);
    set_buckets(9'd511);
    send_word(ACT_INSERT, 32'd1001);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF);
    set_buckets(9'd256);
    send_word(ACT_INSERT, 32'd1001);
    drain();
  endtask

  task automatic test_repeat();
    idle_en = 1'b0;
    for (int i = 0; i < 24; i++) send_word(ACT_INSERT, 32'd0);
    send_word(ACT_LOOKUP, 32'd0);
    idle_en = 1'b1;
    drain();
  endtask

  task automatic test_random();
    logic [CFG_BITS-1:0] mods [9];
    logic [KEY_BITS-1:0] k;
    mods = '{9'd1, 9'd2, 9'd7, 9'd100, 9'd256, 9'd300, 9'd511, 9'd0, 9'd13};
    for (int p = 0; p < 10; p++) begin
      set_buckets(p < 9 ? mods[p] : 9'($urandom_range(0, 511)));
      foreach (pool[i])
        pool[i] = $urandom_range(1) ? $urandom : 32'($signed($urandom_range(0, 400)) - 200);
      idle_en = (p != 4);
      for (int i = 0; i < 180; i++) begin
        k = ($urandom_range(99) < 80) ? pool[$urandom_range(63)] : $urandom;
        send_word(logic'($urandom_range(1)), k);
      end
    end
    idle_en = 1'b1;
    drain();
  endtask

  initial begin
    foreach (tbl_vld[i]) begin
      tbl_vld[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_cnt[i] = 0;
    end
    mod_reg = 9'd256;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_repeat();
    test_random();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && tally_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== frequency_count_hash_table_unit.f =====
sv/fcht_pkg.sv
sv/fcht_datapath.sv
sv/fcht_ctrl.sv
sv/frequency_count_hash_table_unit.sv
tb/sv/tb_frequency_count_hash_table_unit.sv
